>>> rtl/ffl_pkg.sv
// Shared constants and helpers for the fast float natural log pipeline.
package ffl_pkg;

  localparam logic [31:0] ExpOffset = 32'h3f2aaaab;
  localparam logic [31:0] ExpMask   = 32'hff800000;

  // Polynomial coefficients and ln2 as single-precision bit patterns
  localparam logic [31:0] CoefA = 32'h3e6c6078;  //  0.230836749
  localparam logic [31:0] CoefB = 32'hbe8ef46d;  // -0.279208571
  localparam logic [31:0] CoefC = 32'h3ea9e51a;  //  0.331826031
  localparam logic [31:0] CoefD = 32'hbeff712d;  // -0.498910338
  localparam logic [31:0] Ln2   = 32'h3f317218;  //  0.693147182
  localparam logic [31:0] FZero = 32'h00000000;

  localparam int FmaStages = 4;
  localparam int Latency   = 2 + 4 * FmaStages;

  // Leading zero count of a 52-bit word; 52 when the word is zero.
  function automatic logic [5:0] lzc52(input logic [51:0] x);
    logic [5:0] n;
    logic       found;
    n     = 6'd52;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && x[i]) begin
        n     = 6'(51 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/ffl_fma.sv
// Four-stage single-precision fused multiply-add, round to nearest even.
module ffl_fma import ffl_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] y
);

  // stage 1: multiply
  logic [47:0] s1_prod;
  logic [9:0]  s1_esum;
  logic        s1_psign;
  logic        s1_pzero;
  logic [31:0] s1_c;

  always_ff @(posedge clk) begin
    s1_prod  <= {|a[30:23], a[22:0]} * {|b[30:23], b[22:0]};
    s1_esum  <= {2'b0, a[30:23]} + {2'b0, b[30:23]};
    s1_psign <= a[31] ^ b[31];
    s1_pzero <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
    s1_c     <= c;
  end

  // stage 2: align smaller operand to the larger one
  logic [47:0] xp, xc, big_x, small_x;
  logic [9:0]  ebp, ebc, big_e, small_e, shift_amt;
  logic        czero, prod_big, big_s, small_s;
  logic [50:0] small_ext, small_sh, sticky_mask;
  logic        sticky;

  logic [50:0] s2_big;
  logic [50:0] s2_small;
  logic        s2_sub;
  logic        s2_sign;
  logic [9:0]  s2_e;
  logic        s2_zsign;

  always_comb begin
    xp       = s1_prod[47] ? s1_prod : {s1_prod[46:0], 1'b0};
    ebp      = s1_esum + {9'd0, s1_prod[47]};
    xc       = {|s1_c[30:23], s1_c[22:0], 24'd0};
    ebc      = {2'b0, s1_c[30:23]} + 10'd127;
    czero    = (s1_c[30:23] == 8'd0);
    prod_big = !s1_pzero && (czero || ebp >= ebc);
    big_x    = prod_big ? xp : xc;
    big_e    = prod_big ? ebp : ebc;
    big_s    = prod_big ? s1_psign : s1_c[31];
    small_x  = prod_big ? xc : xp;
    small_e  = prod_big ? ebc : ebp;
    small_s  = prod_big ? s1_c[31] : s1_psign;
    shift_amt = big_e - small_e;
    small_ext = {small_x, 3'b000};
    if (shift_amt >= 10'd51) begin
      small_sh    = '0;
      sticky_mask = '1;
    end else begin
      small_sh    = small_ext >> shift_amt[5:0];
      sticky_mask = ~({51{1'b1}} << shift_amt[5:0]);
    end
    sticky = |(small_ext & sticky_mask);
  end

  always_ff @(posedge clk) begin
    s2_big   <= {big_x, 3'b000};
    s2_small <= {small_sh[50:1], small_sh[0] | sticky};
    s2_sub   <= big_s ^ small_s;
    s2_sign  <= big_s;
    s2_e     <= big_e;
    s2_zsign <= s1_pzero && czero && s1_psign && s1_c[31];
  end

  // stage 3: add or subtract, leading zero count
  logic [52:0] sum, sum_abs;
  logic        neg;

  logic [51:0] s3_abs;
  logic [5:0]  s3_lz;
  logic        s3_sign;
  logic [9:0]  s3_e;
  logic        s3_zsign;

  always_comb begin
    if (s2_sub) sum = {2'b0, s2_big} - {2'b0, s2_small};
    else        sum = {2'b0, s2_big} + {2'b0, s2_small};
    neg     = s2_sub && sum[52];
    sum_abs = neg ? (53'd0 - sum) : sum;
  end

  always_ff @(posedge clk) begin
    s3_abs   <= sum_abs[51:0];
    s3_lz    <= lzc52(sum_abs[51:0]);
    s3_sign  <= s2_sign ^ neg;
    s3_e     <= s2_e;
    s3_zsign <= s2_zsign;
  end

  // stage 4: normalize and round
  logic [51:0] norm;
  logic [10:0] exp_r;
  logic        inc;

  always_comb begin
    norm  = s3_abs << s3_lz;
    exp_r = {1'b0, s3_e} - 11'd126 - {5'd0, s3_lz};
    inc   = norm[27] && ((|norm[26:0]) || norm[28]);
  end

  always_ff @(posedge clk) begin
    if (s3_abs == 52'd0) y <= {s3_zsign, 31'd0};
    else                 y <= {s3_sign, {exp_r[7:0], norm[50:28]} + {30'd0, inc}};
  end

endmodule

>>> rtl/fast_float_natural_log.sv
// Top level: pipelined fast natural log approximation on float32 bits.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------
//  request  | start (taken if !busy) | value_bits [31:0]
//  result   | done (one-cycle pulse) | log_bits   [31:0]
//
// One request per cycle. The datapath is two front-end stages plus four chained
// 4-stage fused multiply-add levels. busy is high only during reset; rst clears
// the valid chain and results of requests in flight are dropped. The pipeline
// never stalls.
module fast_float_natural_log import ffl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value_bits,
  output logic        busy,
  output logic        done,
  output logic [31:0] log_bits
);

  logic accept;
  logic [Latency-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[Latency-2:0], accept};
  end

  // front stage 1: exponent split, m - 1 in fixed point, exponent as integer
  logic [31:0] e_off, m_bits;
  logic [24:0] val25;
  logic [25:0] diff26;
  logic [8:0]  k9;

  logic        f_neg;
  logic [24:0] f_abs;
  logic        i_neg;
  logic [8:0]  i_abs;

  always_comb begin
    e_off  = (value_bits - ExpOffset) & ExpMask;
    m_bits = value_bits - e_off;
    // m lies in [2/3, 4/3): exponent is 126 or 127, bit 23 tells which
    val25  = m_bits[23] ? {1'b1, m_bits[22:0], 1'b0} : {1'b0, 1'b1, m_bits[22:0]};
    diff26 = {1'b0, val25} - 26'h1000000;
    k9     = e_off[31:23];
  end

  always_ff @(posedge clk) begin
    f_neg <= diff26[25];
    f_abs <= diff26[25] ? 25'(26'd0 - diff26) : diff26[24:0];
    i_neg <= k9[8];
    i_abs <= k9[8] ? (9'd0 - k9) : k9;
  end

  // front stage 2: pack f and i as floats (both exact)
  logic [5:0]  lz_f, lz_i;
  logic [24:0] norm_f;
  logic [8:0]  norm_i;
  logic [31:0] f_bits, i_bits;

  always_comb begin
    lz_f   = lzc52({f_abs, 27'd0});
    lz_i   = lzc52({i_abs, 43'd0});
    norm_f = f_abs << lz_f[4:0];
    norm_i = i_abs << lz_i[3:0];
  end

  always_ff @(posedge clk) begin
    if (f_abs == 25'd0) f_bits <= FZero;
    else f_bits <= {f_neg, 8'd127 - {2'b0, lz_f}, norm_f[23:1]};
    if (i_abs == 9'd0) i_bits <= FZero;
    else i_bits <= {i_neg, 8'd135 - {2'b0, lz_i}, norm_i[7:0], 15'd0};
  end

  // fused multiply-add levels
  logic [31:0] r1, t1, s1, r2, r3;
  logic [31:0] f_dly [8];
  logic [31:0] s_dly [4];
  logic [31:0] i_dly [12];

  always_ff @(posedge clk) begin
    f_dly[0] <= f_bits;
    for (int n = 1; n < 8; n++) f_dly[n] <= f_dly[n-1];
    s_dly[0] <= s1;
    for (int n = 1; n < 4; n++) s_dly[n] <= s_dly[n-1];
    i_dly[0] <= i_bits;
    for (int n = 1; n < 12; n++) i_dly[n] <= i_dly[n-1];
  end

  ffl_fma u_fma_r1 (.clk(clk), .a(CoefA),  .b(f_bits), .c(CoefB),     .y(r1));
  ffl_fma u_fma_t1 (.clk(clk), .a(CoefC),  .b(f_bits), .c(CoefD),     .y(t1));
  ffl_fma u_fma_sq (.clk(clk), .a(f_bits), .b(f_bits), .c(FZero),     .y(s1));
  ffl_fma u_fma_r2 (.clk(clk), .a(r1),     .b(s1),     .c(t1),        .y(r2));
  ffl_fma u_fma_r3 (.clk(clk), .a(r2),     .b(s_dly[3]), .c(f_dly[7]), .y(r3));
  ffl_fma u_fma_ln (.clk(clk), .a(i_dly[11]), .b(Ln2), .c(r3),        .y(log_bits));

  assign done = vld[Latency-1];

endmodule

>>> rtl/ffl_check.sv
// Port-level checker for the fast float natural log block, bound to the top level.
module ffl_check import ffl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [31:0] value_bits,
  input logic        busy,
  input logic        done,
  input logic [31:0] log_bits
);

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##18 done)
    else $error("request without result");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 18))
    else $error("result without request");

  a_log_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && value_bits == 32'h3f800000) |-> ##18 (log_bits == 32'd0))
    else $error("log of one is not zero");

  a_pure: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && $past(value_bits, 18) == $past(value_bits, 19))
      |-> (log_bits == $past(log_bits)))
    else $error("equal requests gave different results");

endmodule

bind fast_float_natural_log ffl_check u_ffl_check (.*);

>>> tb/testbench.sv
// Self-checking testbench for the fast float natural log pipeline.
module testbench;
  import ffl_pkg::*;

  typedef struct {
    logic [31:0] bits;
    logic        drain;  // hold this request until the pipeline is empty
  } log_req_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] value_bits;
  logic        busy;
  logic        done;
  logic [31:0] log_bits;

  log_req_t    pending_reqs[$];
  logic [31:0] expected_logs[$];
  int          gap_left;
  int          mismatches = 0;

  fast_float_natural_log dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value_bits(value_bits),
    .busy      (busy),
    .done      (done),
    .log_bits  (log_bits)
  );

  // single bits -> double, quieting NaNs
  function automatic real single_to_real(logic [31:0] b);
    logic [22:0] mm;
    int          e;
    if (b[30:23] == 8'hff) begin
      if (b[22:0] != 0) return $bitstoreal({b[31], 11'h7ff, 1'b1, b[21:0], 29'b0});
      return $bitstoreal({b[31], 11'h7ff, 52'b0});
    end
    if (b[30:0] == 0) return $bitstoreal({b[31], 63'b0});
    if (b[30:23] == 0) begin
      e  = -127;
      mm = b[22:0];
      while (!mm[22]) begin
        mm = mm << 1;
        e--;
      end
      return $bitstoreal({b[31], 11'(e + 1023), mm[21:0], 30'b0});
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0});
  endfunction

  // double -> single bits, round to nearest even, subnormals and overflow
  function automatic logic [31:0] real_to_single(real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] base;
    int          ue;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff) begin
      if (d[51:0] != 0) return {d[63], 8'hff, 1'b1, d[50:29]};
      return {d[63], 31'h7f800000};
    end
    if (d[62:52] == 0) return {d[63], 31'b0};
    ue = int'(d[62:52]) - 1023;
    if (ue > 127) return {d[63], 31'h7f800000};
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = (ue >= -126) ? 29 : 29 + (-126 - ue);
    if (sh > 60) return {d[63], 31'b0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    base = (ue >= -126) ? (32'(ue + 126) << 23) : 32'd0;
    return {d[63], 31'(base + kept[31:0])};
  endfunction

  // a*b+c with a single rounding: exact sum, round to odd in double, then to single
  function automatic logic [31:0] fma_single(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    real         p;
    real         cd;
    real         hi;
    real         bb;
    real         lo;
    real         tie;
    real         mag;
    logic [63:0] hb;
    p  = single_to_real(a) * single_to_real(b);
    cd = single_to_real(c);
    hi = p + cd;
    hb = $realtobits(hi);
    if (hb[62:52] == 11'h7ff) return real_to_single(hi);
    bb = hi - p;
    lo = (p - (hi - bb)) + (cd - bb);
    if (lo != 0.0 && !hb[0]) begin
      if ((lo > 0.0) == (hi > 0.0)) hb++;
      else hb--;
      hi = $bitstoreal(hb);
    end
    tie = 2.0 ** 128 - 2.0 ** 103;
    mag = (hi < 0.0) ? -hi : hi;
    if (mag >= tie) return (hi < 0.0) ? 32'hff800000 : 32'h7f800000;
    return real_to_single(hi);
  endfunction

  function automatic logic [31:0] predict_log(logic [31:0] a);
    logic [31:0] e;
    logic [31:0] m;
    logic [31:0] ipart;
    logic [31:0] f;
    logic [31:0] sq;
    logic [31:0] r;
    logic [31:0] t;
    int          ks;
    e     = (a - ExpOffset) & ExpMask;
    ks    = int'($signed(e[31:23]));
    ipart = real_to_single(real'(ks));
    m     = a - e;
    f     = real_to_single(single_to_real(m) - 1.0);
    sq    = real_to_single(single_to_real(f) * single_to_real(f));
    r     = fma_single(CoefA, f, CoefB);
    t     = fma_single(CoefC, f, CoefD);
    r     = fma_single(r, sq, t);
    r     = fma_single(r, sq, f);
    return fma_single(ipart, Ln2, r);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_operand();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return $urandom_range(1, 32'h3f800000);
    if (roll < 80) return {1'b0, 31'($urandom())};
    return $urandom();
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      value_bits <= '0;
      gap_left   <= 0;
    end else begin
      if (start && !busy) expected_logs.push_back(predict_log(value_bits));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain &&
                       (expected_logs.size() > 0 || (start && !busy)))) begin
          start      <= 1'b1;
          value_bits <= pending_reqs[0].bits;
          void'(pending_reqs.pop_front());
          gap_left   <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_logs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result log_bits=%08h", log_bits);
      end else begin
        if (log_bits !== expected_logs[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("log_bits mismatch: expected %08h actual %08h",
                     expected_logs[0], log_bits);
        end
        void'(expected_logs.pop_front());
      end
    end
  end

  initial begin
    logic [31:0] directed[$];
    log_req_t    req;
    rst         = 1'b1;
    directed = '{32'h00000000, 32'h80000000, 32'h3f800000, 32'h7f800000, 32'hff800000,
                 32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001, 32'h007fffff,
                 32'h00800000, 32'h7f7fffff, 32'hbf800000, 32'h3f2aaaab, 32'h3f2aaaaa,
                 32'h3f7fffff, 32'h3e000000, 32'h40000000, 32'h3f000000, 32'h2f800000,
                 32'h3f800001, 32'hc0000000, 32'h3f400000};
    foreach (directed[n]) begin
      req.bits  = directed[n];
      req.drain = 1'b0;
      pending_reqs.push_back(req);
    end
    for (int n = 0; n < 2000; n++) begin
      req.bits  = random_operand();
      req.drain = (n == 1000);
      pending_reqs.push_back(req);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || start) @(posedge clk);
    while (expected_logs.size() > 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && expected_logs.size() == 0)
      $display("fast_float_natural_log verification clean");
    else
      $display("fast_float_natural_log verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("fast_float_natural_log verification failed");
    $finish;
  end

endmodule
